@@ rtl/core/lci_pkg.sv @@
// Shared constants and helpers for the line/circle crossing pipeline.
package lci_pkg;

  localparam int COORD_W    = 32;  // default coordinate width
  localparam int FRAC_W     = 16;  // default fraction bits
  localparam int TOL_W      = 16;  // width of the tolerance register
  localparam int MUL_CHUNK  = 32;  // partial product operand width

  // Number of MUL_CHUNK slices that cover a magnitude of w bits.
  function automatic int mul_chunks(int w);
    return (w + MUL_CHUNK - 1) / MUL_CHUNK;
  endfunction

  // Register stages from operands to product in lci_mul.
  function automatic int mul_lat(int aw, int bw);
    return mul_chunks(aw) * mul_chunks(bw) + 3;
  endfunction

endpackage

@@ rtl/core/line_circle_intersection.sv @@
// Top level: line/circle crossing point, fully pipelined, one request per cycle.
//
// Takes one request per clock while the output is not held, and returns one
// crossing point per request, in order. The pipe holds 7 boundary stages plus
// three multiplier pipelines, a floor square root that resolves one root bit
// per stage (about 2*COORD_WIDTH+3 stages) and a rounding divider that
// resolves one quotient bit per stage (COORD_WIDTH+2 stages). The whole pipe
// advances together; when the output is held by out_ready low every stage
// holds, so in_ready follows out_ready whenever the output register is full.
// With d = end - start, e = start - center the point
// is start + d * (+-sqrt(A*r^2 - area^2) - d.e) / A, A = |d|^2, area = e x d.
// A request is invalid (zero point) when either object is absent, when the two
// line points coincide, or when area^2 > (r + miss_tolerance)^2 * A. A negative
// discriminant within the tolerance band gives the foot of the perpendicular.
// The division rounds to nearest, ties away from zero; results saturate to
// the coordinate range. cfg_write loads miss_tolerance (raw Q units); write it
// only while no request is in flight.
module line_circle_intersection #(
  parameter int COORD_WIDTH = lci_pkg::COORD_W,
  parameter int FRAC_BITS   = lci_pkg::FRAC_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [lci_pkg::TOL_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic [COORD_WIDTH-2:0]        circle_radius,
  input  logic                          take_first,
  input  logic                          line_real,
  input  logic                          circle_real,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] cross_x,
  output logic signed [COORD_WIDTH-1:0] cross_y,
  output logic                          point_valid
);
  import lci_pkg::*;

  // datapath widths
  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;                                   // differences
  localparam int TW   = ((CW - 1) > TOL_W ? (CW - 1) : TOL_W) + 1; // r + tol
  localparam int OW1  = (DW > TW + 1) ? DW : TW + 1;              // first mul operands
  localparam int PW1  = 2 * OW1;
  localparam int AWID = PW1 + 1;                                  // A, area, d.e
  localparam int PW2  = 2 * AWID;                                 // squares times A
  localparam int NMW  = AWID + 2;                                 // numerator
  localparam int PPW  = NMW + OW1;
  localparam int NW   = PPW + 1;
  localparam int QW   = CW + 2;                                   // |offset| < 2^QW
  localparam int SW   = CW + 4;

  // stage counts
  localparam int L1 = mul_lat(OW1, OW1);
  localparam int L2 = mul_lat(AWID, AWID);
  localparam int LS = PW2 / 2;
  localparam int L3 = mul_lat(NMW, OW1);
  localparam int LD = QW;
  localparam int LT = 7 + L1 + L2 + LS + L3 + LD;

  localparam logic [TOL_W-1:0] TOL_RST =
    TOL_W'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

  localparam logic signed [SW-1:0] SAT_HI = {5'b00000, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {5'b11111, {(CW-1){1'b0}}};

  // per-request side data riding along the pipe
  typedef struct packed {
    logic signed [CW-1:0]   sx;
    logic signed [CW-1:0]   sy;
    logic signed [OW1-1:0]  dx;
    logic signed [OW1-1:0]  dy;
    logic signed [AWID-1:0] a;
    logic signed [AWID-1:0] bq;
    logic                   first;
    logic                   ok;
    logic                   zero;
    logic                   miss;
    logic                   negx;
    logic                   negy;
  } side_t;

  localparam int SBW = $bits(side_t);

  function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    c = v;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end
    return c[CW-1:0];
  endfunction

  logic             adv;
  logic [LT-1:0]    vld;
  logic [TOL_W-1:0] miss_tol;

  // whole pipe moves unless the output register is full and held
  assign adv       = !vld[LT-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[LT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      miss_tol <= TOL_RST;
    end else if (cfg_write) begin
      miss_tol <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LT-2:0], in_valid && in_ready};
    end
  end

  // ---------------- S1: differences, radius terms
  side_t                  sd1, sd1_next;
  logic signed [OW1-1:0]  ex_q, ey_q, rt_q, r_q;

  always_comb begin
    sd1_next.sx    = start_x;
    sd1_next.sy    = start_y;
    sd1_next.dx    = OW1'(end_x) - OW1'(start_x);
    sd1_next.dy    = OW1'(end_y) - OW1'(start_y);
    sd1_next.a     = '0;
    sd1_next.bq    = '0;
    sd1_next.first = take_first;
    sd1_next.ok    = line_real && circle_real;
    sd1_next.zero  = 1'b0;
    sd1_next.miss  = 1'b0;
    sd1_next.negx  = 1'b0;
    sd1_next.negy  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd1       <= sd1_next;
      ex_q      <= OW1'(start_x) - OW1'(center_x);
      ey_q      <= OW1'(start_y) - OW1'(center_y);
      rt_q      <= $signed(OW1'(circle_radius) + OW1'(miss_tol));
      r_q       <= $signed(OW1'(circle_radius));
    end
  end

  logic signed [PW1-1:0] m1, m2, m3, m4, m5, m6, m8, m9;

  lci_mul #(.AW(OW1), .BW(OW1)) u_m1 (.clk, .en(adv), .a(sd1.dy), .b(ex_q), .p(m1));
  lci_mul #(.AW(OW1), .BW(OW1)) u_m2 (.clk, .en(adv), .a(sd1.dx), .b(ey_q), .p(m2));
  lci_mul #(.AW(OW1), .BW(OW1)) u_m3 (.clk, .en(adv), .a(sd1.dx), .b(sd1.dx), .p(m3));
  lci_mul #(.AW(OW1), .BW(OW1)) u_m4 (.clk, .en(adv), .a(sd1.dy), .b(sd1.dy), .p(m4));
  lci_mul #(.AW(OW1), .BW(OW1)) u_m5 (.clk, .en(adv), .a(sd1.dx), .b(ex_q), .p(m5));
  lci_mul #(.AW(OW1), .BW(OW1)) u_m6 (.clk, .en(adv), .a(sd1.dy), .b(ey_q), .p(m6));
  lci_mul #(.AW(OW1), .BW(OW1)) u_m8 (.clk, .en(adv), .a(rt_q), .b(rt_q), .p(m8));
  lci_mul #(.AW(OW1), .BW(OW1)) u_m9 (.clk, .en(adv), .a(r_q), .b(r_q), .p(m9));

  logic [L1*SBW-1:0] dl1;
  side_t             sd1o;

  always_ff @(posedge clk) begin
    if (adv) begin
      dl1 <= {dl1[(L1-1)*SBW-1:0], sd1};
    end
  end
  assign sd1o = side_t'(dl1[L1*SBW-1 -: SBW]);

  // ---------------- S2: A, cross product, dot product
  side_t                  sd2, sd2_next;
  logic signed [AWID-1:0] area_q, rt2_q, r2_q;

  always_comb begin
    sd2_next      = sd1o;
    sd2_next.a    = AWID'(m3) + AWID'(m4);
    sd2_next.bq   = AWID'(m5) + AWID'(m6);
    sd2_next.zero = (sd1o.dx == '0) && (sd1o.dy == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd2      <= sd2_next;
      area_q   <= AWID'(m1) - AWID'(m2);
      rt2_q    <= AWID'(m8);
      r2_q     <= AWID'(m9);
    end
  end

  logic signed [PW2-1:0] m7, m10, m11;

  lci_mul #(.AW(AWID), .BW(AWID)) u_m7  (.clk, .en(adv), .a(area_q), .b(area_q), .p(m7));
  lci_mul #(.AW(AWID), .BW(AWID)) u_m10 (.clk, .en(adv), .a(rt2_q), .b(sd2.a), .p(m10));
  lci_mul #(.AW(AWID), .BW(AWID)) u_m11 (.clk, .en(adv), .a(r2_q), .b(sd2.a), .p(m11));

  logic [L2*SBW-1:0] dl2;
  side_t             sd2o;

  always_ff @(posedge clk) begin
    if (adv) begin
      dl2 <= {dl2[(L2-1)*SBW-1:0], sd2};
    end
  end
  assign sd2o = side_t'(dl2[L2*SBW-1 -: SBW]);

  // ---------------- S3: miss test and clamped discriminant
  // B^2 - A*C reduces to A*r^2 - area^2, exactly.
  side_t                 sd3, sd3_next;
  logic [PW2-1:0]        disc_q;
  logic signed [PW2:0]   disc;

  assign disc = (PW2+1)'(m11) - (PW2+1)'(m7);

  always_comb begin
    sd3_next      = sd2o;
    sd3_next.miss = m7 > m10;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd3      <= sd3_next;
      disc_q   <= disc[PW2] ? '0 : disc[PW2-1:0];
    end
  end

  logic [PW2/2-1:0] root;

  lci_sqrt #(.XW(PW2)) u_sqrt (.clk, .en(adv), .x(disc_q), .root(root));

  logic [LS*SBW-1:0] dls;
  side_t             sd3o;

  always_ff @(posedge clk) begin
    if (adv) begin
      dls <= {dls[(LS-1)*SBW-1:0], sd3};
    end
  end
  assign sd3o = side_t'(dls[LS*SBW-1 -: SBW]);

  // ---------------- S4: numerator +-root - d.e
  side_t                 sd4;
  logic signed [NMW-1:0] num_q;
  logic signed [NMW-1:0] rootx;

  assign rootx = $signed(NMW'(root));

  always_ff @(posedge clk) begin
    if (adv) begin
      sd4   <= sd3o;
      num_q <= (sd3o.first ? rootx : -rootx) - NMW'(sd3o.bq);
    end
  end

  logic signed [PPW-1:0] px, py;

  lci_mul #(.AW(NMW), .BW(OW1)) u_m12 (.clk, .en(adv), .a(num_q), .b(sd4.dx), .p(px));
  lci_mul #(.AW(NMW), .BW(OW1)) u_m13 (.clk, .en(adv), .a(num_q), .b(sd4.dy), .p(py));

  logic [L3*SBW-1:0] dl3;
  side_t             sd4o;

  always_ff @(posedge clk) begin
    if (adv) begin
      dl3 <= {dl3[(L3-1)*SBW-1:0], sd4};
    end
  end
  assign sd4o = side_t'(dl3[L3*SBW-1 -: SBW]);

  // ---------------- S5: round-to-nearest operands, 2|P|+A over 2A
  side_t             sd5, sd5_next;
  logic [NW-1:0]     nx_q, ny_q;
  logic [AWID-1:0]   dv_q;
  logic [PPW-1:0]    absx, absy;

  assign absx = $unsigned(px[PPW-1] ? -px : px);
  assign absy = $unsigned(py[PPW-1] ? -py : py);

  always_comb begin
    sd5_next      = sd4o;
    sd5_next.negx = px[PPW-1];
    sd5_next.negy = py[PPW-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd5      <= sd5_next;
      nx_q     <= {absx, 1'b0} + NW'($unsigned(sd4o.a));
      ny_q     <= {absy, 1'b0} + NW'($unsigned(sd4o.a));
      dv_q     <= {sd4o.a[AWID-2:0], 1'b0};
    end
  end

  logic [QW-1:0] qx, qy;

  lci_div #(.NW(NW), .DVW(AWID), .QW(QW)) u_divx (.clk, .en(adv), .n(nx_q), .d(dv_q), .q(qx));
  lci_div #(.NW(NW), .DVW(AWID), .QW(QW)) u_divy (.clk, .en(adv), .n(ny_q), .d(dv_q), .q(qy));

  logic [LD*SBW-1:0] dld;
  side_t             sd5o;

  always_ff @(posedge clk) begin
    if (adv) begin
      dld <= {dld[(LD-1)*SBW-1:0], sd5};
    end
  end
  assign sd5o = side_t'(dld[LD*SBW-1 -: SBW]);

  // ---------------- S6: restore sign of the offset
  side_t                sd6;
  logic signed [QW:0]   qsx_q, qsy_q;

  always_ff @(posedge clk) begin
    if (adv) begin
      sd6   <= sd5o;
      qsx_q <= sd5o.negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      qsy_q <= sd5o.negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    end
  end

  // ---------------- S7: add to start point, saturate, output register
  logic signed [SW-1:0] sumx, sumy;
  logic                 hit;

  assign sumx = SW'(sd6.sx) + SW'(qsx_q);
  assign sumy = SW'(sd6.sy) + SW'(qsy_q);
  assign hit  = sd6.ok && !sd6.zero && !sd6.miss;

  always_ff @(posedge clk) begin
    if (adv) begin
      cross_x     <= hit ? sat(sumx) : '0;
      cross_y     <= hit ? sat(sumy) : '0;
      point_valid <= hit;
    end
  end

endmodule

@@ rtl/core/lci_mul.sv @@
// Pipelined signed multiplier built from 32x32 partial products, one per stage.
module lci_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p
);
  import lci_pkg::*;

  localparam int NA  = mul_chunks(AW);
  localparam int NB  = mul_chunks(BW);
  localparam int NS  = NA * NB;
  localparam int AMW = NA * MUL_CHUNK;
  localparam int BMW = NB * MUL_CHUNK;
  localparam int PW  = AW + BW;
  localparam int PPW = 2 * MUL_CHUNK;
  localparam int LSH = MUL_CHUNK * ((NS - 1) / NB + (NS - 1) % NB);

  logic [AMW-1:0] am  [0:NS];
  logic [BMW-1:0] bm  [0:NS];
  logic           ng  [0:NS];
  logic [PPW-1:0] pp  [1:NS];
  logic [PW-1:0]  acc [1:NS];
  logic [PW-1:0]  accf;
  logic           ngf;

  // sign/magnitude split
  always_ff @(posedge clk) begin
    if (en) begin
      am[0] <= AMW'($unsigned(a[AW-1] ? -a : a));
      bm[0] <= BMW'($unsigned(b[BW-1] ? -b : b));
      ng[0] <= a[AW-1] ^ b[BW-1];
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_step
    localparam int SI = (k - 1) / NB;
    localparam int SJ = (k - 1) % NB;
    always_ff @(posedge clk) begin
      if (en) begin
        pp[k] <= PPW'(am[k-1][SI*MUL_CHUNK +: MUL_CHUNK]) *
                 PPW'(bm[k-1][SJ*MUL_CHUNK +: MUL_CHUNK]);
        am[k] <= am[k-1];
        bm[k] <= bm[k-1];
        ng[k] <= ng[k-1];
      end
    end
    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          acc[k] <= '0;
        end
      end
    end else begin : g_acc
      localparam int PSH = MUL_CHUNK * ((k - 2) / NB + (k - 2) % NB);
      always_ff @(posedge clk) begin
        if (en) begin
          acc[k] <= acc[k-1] + (PW'(pp[k-1]) << PSH);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      accf <= acc[NS] + (PW'(pp[NS]) << LSH);
      ngf  <= ng[NS];
      p    <= ngf ? -$signed(accf) : $signed(accf);
    end
  end

endmodule

@@ rtl/core/lci_sqrt.sv @@
// Pipelined floor square root, one result bit per stage.
module lci_sqrt #(
  parameter int XW = 134
) (
  input  logic              clk,
  input  logic              en,
  input  logic [XW-1:0]     x,
  output logic [XW/2-1:0]   root
);

  localparam int S = XW / 2;

  logic [S+1:0]  rem [1:S];
  logic [S-1:0]  rt  [1:S];
  logic [XW-1:0] xr  [1:S-1];

  for (genvar k = 1; k <= S; k++) begin : g_step
    logic [S+1:0]  rem_p;
    logic [S-1:0]  rt_p;
    logic [XW-1:0] xr_p;
    logic [S+3:0]  cand;
    logic [S+3:0]  trial;

    if (k == 1) begin : g_in
      assign rem_p = '0;
      assign rt_p  = '0;
      assign xr_p  = x;
    end else begin : g_prev
      assign rem_p = rem[k-1];
      assign rt_p  = rt[k-1];
      assign xr_p  = xr[k-1];
    end

    assign cand  = {rem_p, xr_p[XW-1 -: 2]};
    assign trial = {2'b00, rt_p, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (cand >= trial) begin
          rem[k] <= (S+2)'(cand - trial);
          rt[k]  <= {rt_p[S-2:0], 1'b1};
        end else begin
          rem[k] <= cand[S+1:0];
          rt[k]  <= {rt_p[S-2:0], 1'b0};
        end
      end
    end

    if (k < S) begin : g_shift
      always_ff @(posedge clk) begin
        if (en) begin
          xr[k] <= xr_p << 2;
        end
      end
    end
  end

  assign root = rt[S];

endmodule

@@ rtl/core/lci_div.sv @@
// Pipelined restoring divider, one quotient bit per stage; quotient below 2^QW.
module lci_div #(
  parameter int NW  = 103,
  parameter int DVW = 67,
  parameter int QW  = 34
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NW-1:0]    n,
  input  logic [DVW-1:0]   d,
  output logic [QW-1:0]    q
);

  logic [DVW-1:0] rem [1:QW];
  logic [QW-1:0]  qq  [1:QW];
  logic [QW-1:0]  nl  [1:QW-1];
  logic [DVW-1:0] dd  [1:QW-1];

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DVW-1:0] rem_p;
    logic [QW-1:0]  q_p;
    logic [QW-1:0]  nl_p;
    logic [DVW-1:0] d_p;
    logic [DVW:0]   cand;

    if (k == 1) begin : g_in
      assign rem_p = DVW'(n >> QW);
      assign q_p   = '0;
      assign nl_p  = n[QW-1:0];
      assign d_p   = d;
    end else begin : g_prev
      assign rem_p = rem[k-1];
      assign q_p   = qq[k-1];
      assign nl_p  = nl[k-1];
      assign d_p   = dd[k-1];
    end

    assign cand = {rem_p, nl_p[QW-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (cand >= {1'b0, d_p}) begin
          rem[k] <= DVW'(cand - {1'b0, d_p});
          qq[k]  <= {q_p[QW-2:0], 1'b1};
        end else begin
          rem[k] <= cand[DVW-1:0];
          qq[k]  <= {q_p[QW-2:0], 1'b0};
        end
      end
    end

    if (k < QW) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          nl[k] <= nl_p << 1;
          dd[k] <= d_p;
        end
      end
    end
  end

  assign q = qq[QW];

endmodule

@@ rtl/core/lci_checker.sv @@
// Port-level checks for line_circle_intersection, bound to the top level.
module lci_checker #(
  parameter int COORD_WIDTH = lci_pkg::COORD_W
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [COORD_WIDTH-1:0] cross_x,
  input logic signed [COORD_WIDTH-1:0] cross_y,
  input logic                          point_valid
);

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cross_x) && $stable(cross_y)
      && $stable(point_valid))
    else $error("result changed while stalled");

  // an invalid point reads as the origin
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |-> cross_x == '0 && cross_y == '0)
    else $error("invalid point not zero");

  // the pipe never stalls input while the output register is empty
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // reset empties the pipe
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

endmodule

bind line_circle_intersection lci_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lci_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .cross_x     (cross_x),
  .cross_y     (cross_y),
  .point_valid (point_valid)
);

@@ tb/lci_checker.sv @@
// Checker: watches both channels, predicts each crossing point and compares results.
module lci_scoreboard (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic [30:0]        circle_radius,
  input  logic               take_first,
  input  logic               line_real,
  input  logic               circle_real,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] cross_x,
  input  logic signed [31:0] cross_y,
  input  logic               point_valid,
  output int                 fail_count,
  output int                 pending_points
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRED_DEPTH = 1024;

  typedef logic signed [255:0] wide_t;
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               ok;
  } point_t;

  point_t      pred_mem[PRED_DEPTH];
  int          wr_cnt;
  int          rd_cnt;
  logic [15:0] tol;

  // floor sqrt, bitwise
  function automatic wide_t isqrt(wide_t n);
    wide_t res;
    wide_t bitv;
    wide_t t;
    res = 0;
    bitv = wide_t'(1) << 254;
    while (bitv > n && bitv != 0) bitv = bitv >> 2;
    while (bitv != 0) begin
      t = res + bitv;
      if (n >= t) begin
        n = n - t;
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // round to nearest, ties away from zero; d > 0
  function automatic wide_t round_div(wide_t n, wide_t d);
    wide_t mag;
    wide_t q;
    mag = (n < 0) ? -n : n;
    q = (2 * mag + d) / (2 * d);
    return (n < 0) ? -q : q;
  endfunction

  function automatic logic signed [31:0] clamp32(wide_t v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic point_t predict_crossing();
    point_t p;
    wide_t sx, sy, dx, dy, ex0, ey0, a, area, rt, bq, cq, disc, root, num, r;
    p = '0;
    if (!line_real || !circle_real) return p;
    sx = start_x;
    sy = start_y;
    dx = wide_t'(end_x) - sx;
    dy = wide_t'(end_y) - sy;
    ex0 = sx - wide_t'(center_x);
    ey0 = sy - wide_t'(center_y);
    a = dx * dx + dy * dy;
    if (a == 0) return p;
    area = dy * ex0 - dx * ey0;
    r = wide_t'({1'b0, circle_radius});
    rt = r + wide_t'({1'b0, tol});
    if (area * area > rt * rt * a) return p;
    bq = dx * ex0 + dy * ey0;
    cq = ex0 * ex0 + ey0 * ey0 - r * r;
    disc = bq * bq - a * cq;
    root = (disc < 0) ? 0 : isqrt(disc);
    if (!take_first) root = -root;
    num = root - bq;
    p.px = clamp32(sx + round_div(num * dx, a));
    p.py = clamp32(sy + round_div(num * dy, a));
    p.ok = 1'b1;
    return p;
  endfunction

  assign pending_points = wr_cnt - rd_cnt;

  always @(posedge clk) begin
    point_t want;
    if (rst) begin
      tol <= 16'd7;
      fail_count <= 0;
      wr_cnt <= 0;
      rd_cnt <= 0;
    end else begin
      if (cfg_write) tol <= cfg_data;
      if (in_valid && in_ready) begin
        pred_mem[wr_cnt % PRED_DEPTH] <= predict_crossing();
        wr_cnt <= wr_cnt + 1;
      end
      if (out_valid && out_ready) begin
        if (wr_cnt == rd_cnt) begin
          $display("%0t: unexpected result x=%h y=%h v=%b", $time, cross_x, cross_y,
                   point_valid);
          fail_count <= fail_count + 1;
        end else begin
          want = pred_mem[rd_cnt % PRED_DEPTH];
          rd_cnt <= rd_cnt + 1;
          if (want.px !== cross_x || want.py !== cross_y || want.ok !== point_valid) begin
            $display("%0t: mismatch expected x=%h y=%h v=%b actual x=%h y=%h v=%b",
                     $time, want.px, want.py, want.ok, cross_x, cross_y, point_valid);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/tb.sv @@
// Testbench top: drives requests and tolerance writes, gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT = 140;  // above the block's pipeline depth at the default width

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] start_x = 0, start_y = 0, end_x = 0, end_y = 0;
  logic signed [31:0] center_x = 0, center_y = 0;
  logic [30:0] circle_radius = 0;
  logic take_first = 0, line_real = 0, circle_real = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] cross_x, cross_y;
  logic point_valid;
  int fail_count;
  int pending_points;
  bit long_hold = 0;  // set by the sender to request one long output stall

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  line_circle_intersection dut (.*);
  lci_scoreboard chk (.*);

  // Send one request, after a random gap, and wait for acceptance.
  task automatic send(input logic signed [31:0] sx, sy, ex, ey, cx, cy,
                      input logic [30:0] r, input logic tf, lr, cr);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    start_x <= sx; start_y <= sy; end_x <= ex; end_y <= ey;
    center_x <= cx; center_y <= cy; circle_radius <= r;
    take_first <= tf; line_real <= lr; circle_real <= cr;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Geometry scaled by a random shift: small cases hit the circle often,
  // large ones exercise saturation and the top bits.
  task automatic send_random();
    int sh;
    logic signed [31:0] cx, cy, sx, sy, ex, ey;
    logic [30:0] r;
    sh = $urandom_range(0, 9) == 0 ? 31 : $urandom_range(4, 22);
    cx = $signed($urandom) >>> (31 - sh);
    cy = $signed($urandom) >>> (31 - sh);
    r = 31'($urandom >> (32 - sh));
    if ($urandom_range(0, 7) == 0) begin
      sx = $urandom; sy = $urandom; ex = $urandom; ey = $urandom;
      r = 31'($urandom);
    end else begin
      sx = cx + ($signed($urandom) >>> (31 - sh));
      sy = cy + ($signed($urandom) >>> (31 - sh));
      ex = cx + ($signed($urandom) >>> (31 - sh));
      ey = cy + ($signed($urandom) >>> (31 - sh));
      if ($urandom_range(0, 30) == 0) begin
        ex = sx; ey = sy;
      end
    end
    send(sx, sy, ex, ey, cx, cy, r, 1'($urandom), $urandom_range(0, 15) != 0,
         $urandom_range(0, 15) != 0);
  endtask

  // Idle until every expected result is out, plus the pipe latency.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_points != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic write_tol(input logic [15:0] v);
    cfg_write <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 0;
  endtask

  // Receiver: random stalls, with bursts of no stall, and one long hold.
  initial begin
    int wait_n;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      wait_n = $urandom_range(0, 1) ? 0 : $urandom_range(0, 15);
      if (wait_n != 0) begin
        out_ready <= 0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
    end
  end

  initial begin
    logic [15:0] tol_set[4];
    tol_set = '{16'd0, 16'hffff, 16'd300, 16'd7};
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset tolerance, then a few cases of note
    // secant through a unit circle, both roots
    send(-32'sd131072, 0, 32'sd131072, 0, 0, 0, 31'd65536, 1'b1, 1'b1, 1'b1);
    send(-32'sd131072, 0, 32'sd131072, 0, 0, 0, 31'd65536, 1'b0, 1'b1, 1'b1);
    // line or circle missing
    send(-32'sd131072, 0, 32'sd131072, 0, 0, 0, 31'd65536, 1'b1, 1'b0, 1'b1);
    send(-32'sd131072, 0, 32'sd131072, 0, 0, 0, 31'd65536, 1'b1, 1'b1, 1'b0);
    // zero length
    send(32'sd5, 32'sd5, 32'sd5, 32'sd5, 0, 0, 31'd65536, 1'b1, 1'b1, 1'b1);
    // tangent, just inside tolerance, just outside
    send(-32'sd131072, 32'sd65536, 32'sd131072, 32'sd65536, 0, 0, 31'd65536,
         1'b1, 1'b1, 1'b1);
    send(-32'sd131072, 32'sd65540, 32'sd131072, 32'sd65540, 0, 0, 31'd65536,
         1'b0, 1'b1, 1'b1);
    send(-32'sd131072, 32'sd65550, 32'sd131072, 32'sd65550, 0, 0, 31'd65536,
         1'b1, 1'b1, 1'b1);
    // field extremes and saturation
    send(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
         32'sh7fffffff, 32'sh80000000, 31'h7fffffff, 1'b1, 1'b1, 1'b1);
    send(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
         32'sh80000000, 32'sh80000000, 31'h7fffffff, 1'b0, 1'b1, 1'b1);
    send(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
         0, 0, 31'd0, 1'b1, 1'b1, 1'b1);
    send(-32'sd1, -32'sd1, 0, 0, 0, 0, 31'd0, 1'b0, 1'b1, 1'b1);
    send(0, 0, 32'sh7fffffff, 32'sd1, 32'sh80000000, 32'sh7fffffff,
         31'h7fffffff, 1'b1, 1'b1, 1'b1);

    // random phases over several tolerance settings
    foreach (tol_set[p]) begin
      drain();
      write_tol(tol_set[p]);
      for (int i = 0; i < 175; i++) begin
        if (p == 1 && i == 20) long_hold = 1;  // block fills, input stalls
        send_random();
      end
    end
    drain();
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/lci_pkg.sv
rtl/core/lci_mul.sv
rtl/core/lci_sqrt.sv
rtl/core/lci_div.sv
rtl/core/line_circle_intersection.sv
rtl/core/lci_checker.sv
tb/lci_checker.sv
tb/tb.sv
